>>> rtl/core/x86_modrm_effective_address_assert.svh
// assertion macros used by the checker file
`ifndef X86_MODRM_EFFECTIVE_ADDRESS_ASSERT_SVH
`define X86_MODRM_EFFECTIVE_ADDRESS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define XMEA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define XMEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/xmea_pkg.sv
package xmea_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MODRM = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;

  localparam logic [15:0] MASK16 = 16'hFFFF;

  // held decode state and registered register file reads
  typedef struct packed {
    logic        wide;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [31:0] rd0;
    logic [31:0] rd1;
    logic [2:0]  len;
  } ea_src_t;

  typedef struct packed {
    logic [2:0]  length;
    logic        stack_segment;
    logic [31:0] offset;
  } ea_res_t;

  // displacement length in bytes for a mod field
  function automatic logic [2:0] disp_size(input logic [1:0] md, input logic disp_as_base,
                                           input logic wide);
    logic [2:0] sz;
    begin
      sz = 3'd0;
      if (md == 2'd1) sz = 3'd1;
      else if (md == 2'd2) sz = wide ? 3'd4 : 3'd2;
      else if (md == 2'd0 && disp_as_base) sz = wide ? 3'd4 : 3'd2;
      return sz;
    end
  endfunction

endpackage

>>> rtl/core/x86_modrm_effective_address.sv
// x86 ModR/M and SIB effective address unit. Each beat is a register write, a ModR/M
// byte that opens a decode, or a following SIB or displacement byte; one beat is taken
// per cycle while in_tready is high. The beat that completes a decode reads the register
// file through two registered read ports, the next cycle forms the offset with one
// three-input add, and the result joins a two-entry output queue whose output register
// drives the output. in_tready drops only while the queue is full and a further result
// waits in the address stage; a sustained rate of one beat per cycle holds whenever
// results are taken as they appear.
module x86_modrm_effective_address
  import xmea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // reg_index[2:0], reg_value[34:3], byte_value[42:35], address_32[43], zero[47:44]
  input  logic [47:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // offset[31:0], stack_segment[32], length[35:33], zero[39:36]
  output logic [39:0] out_tdata
);

  logic    beat_ok;
  logic    b_valid;
  logic    b_take;
  logic    q_full;
  ea_src_t src;
  ea_res_t res;
  ea_res_t q_data;

  assign in_tready = !(b_valid && q_full);
  assign beat_ok   = in_tvalid && in_tready;
  assign b_take    = b_valid && !q_full;

  // byte sequencer and register file
  xmea_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_ok    (beat_ok),
    .op         (in_tuser),
    .reg_index  (in_tdata[2:0]),
    .reg_value  (in_tdata[34:3]),
    .byte_value (in_tdata[42:35]),
    .address_32 (in_tdata[43]),
    .b_take     (b_take),
    .b_valid    (b_valid),
    .src        (src)
  );

  // offset and segment default
  xmea_agen u_agen (
    .src (src),
    .res (res)
  );

  // result queue
  xmea_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_take),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {4'd0, q_data.length, q_data.stack_segment, q_data.offset};

endmodule

>>> rtl/core/xmea_seq.sv
module xmea_seq
  import xmea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_ok,
  input  logic [1:0]  op,
  input  logic [2:0]  reg_index,
  input  logic [31:0] reg_value,
  input  logic [7:0]  byte_value,
  input  logic        address_32,
  input  logic        b_take,
  output logic        b_valid,
  output ea_src_t     src
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SIB  = 2'd1;
  localparam logic [1:0] PH_DISP = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic        wide_r, wide_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [7:0]  sib_r, sib_nxt;
  logic [31:0] disp_r, disp_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  taken_r, taken_nxt;
  logic        b_valid_r, b_valid_nxt;
  logic        fin;
  logic [2:0]  header;
  logic [1:0]  pos;

  logic [31:0] regs_mem [8];
  logic [7:0]  regs_ok_r;
  logic [31:0] rd0_r, rd1_r;
  logic        rd0_ok_r, rd1_ok_r;
  logic [2:0]  addr0, addr1;

  // per-beat sequencing of modrm, sib and displacement bytes
  always_comb begin
    phase_nxt = phase_r;
    wide_nxt  = wide_r;
    modrm_nxt = modrm_r;
    sib_nxt   = sib_r;
    disp_nxt  = disp_r;
    left_nxt  = left_r;
    taken_nxt = taken_r;
    fin       = 1'b0;
    header    = (wide_r && modrm_r[2:0] == 3'd4) ? 3'd2 : 3'd1;
    pos       = 2'(taken_r - header);
    if (beat_ok) begin
      case (op)
        OP_MODRM: begin
          wide_nxt  = address_32;
          modrm_nxt = byte_value;
          sib_nxt   = 8'd0;
          disp_nxt  = 32'd0;
          taken_nxt = 3'd1;
          if (address_32 && byte_value[2:0] == 3'd4) begin
            phase_nxt = PH_SIB;
            left_nxt  = 3'd0;
          end else begin
            left_nxt = disp_size(byte_value[7:6],
                                 address_32 ? (byte_value[2:0] == 3'd5)
                                            : (byte_value[2:0] == 3'd6),
                                 address_32);
            if (left_nxt == 3'd0) begin
              fin       = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_DISP;
            end
          end
        end
        OP_BYTE: begin
          case (phase_r)
            PH_SIB: begin
              sib_nxt   = byte_value;
              taken_nxt = 3'd2;
              left_nxt  = disp_size(modrm_r[7:6], byte_value[2:0] == 3'd5, 1'b1);
              if (left_nxt == 3'd0) begin
                fin       = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_DISP;
              end
            end
            PH_DISP: begin
              case (pos)
                2'd0:    disp_nxt[7:0]   = disp_r[7:0]   | byte_value;
                2'd1:    disp_nxt[15:8]  = disp_r[15:8]  | byte_value;
                2'd2:    disp_nxt[23:16] = disp_r[23:16] | byte_value;
                default: disp_nxt[31:24] = disp_r[31:24] | byte_value;
              endcase
              taken_nxt = taken_r + 3'd1;
              left_nxt  = left_r - 3'd1;
              if (left_nxt == 3'd0) begin
                fin       = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // register file read addresses from the final decode bytes
  always_comb begin
    if (wide_nxt) begin
      addr0 = (modrm_nxt[2:0] == 3'd4) ? sib_nxt[2:0] : modrm_nxt[2:0];
      addr1 = sib_nxt[5:3];
    end else begin
      case (modrm_nxt[2:0])
        3'd2, 3'd3, 3'd6: addr0 = 3'd5;
        3'd4:             addr0 = 3'd6;
        3'd5:             addr0 = 3'd7;
        default:          addr0 = 3'd3;
      endcase
      addr1 = modrm_nxt[0] ? 3'd7 : 3'd6;
    end
  end

  assign b_valid_nxt = fin ? 1'b1 : (b_take ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wide_r    <= 1'b0;
      modrm_r   <= 8'd0;
      sib_r     <= 8'd0;
      disp_r    <= 32'd0;
      left_r    <= 3'd0;
      taken_r   <= 3'd0;
      b_valid_r <= 1'b0;
      regs_ok_r <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      wide_r    <= wide_nxt;
      modrm_r   <= modrm_nxt;
      sib_r     <= sib_nxt;
      disp_r    <= disp_nxt;
      left_r    <= left_nxt;
      taken_r   <= taken_nxt;
      b_valid_r <= b_valid_nxt;
      if (beat_ok && op == OP_WRITE) regs_ok_r[reg_index] <= 1'b1;
    end
  end

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (beat_ok && op == OP_WRITE) regs_mem[reg_index] <= reg_value;
    if (fin) begin
      rd0_r    <= regs_mem[addr0];
      rd1_r    <= regs_mem[addr1];
      rd0_ok_r <= regs_ok_r[addr0];
      rd1_ok_r <= regs_ok_r[addr1];
    end
  end

  // held state stays put until the next beat, so it feeds the address stage
  assign b_valid   = b_valid_r;
  assign src.wide  = wide_r;
  assign src.modrm = modrm_r;
  assign src.sib   = sib_r;
  assign src.disp  = disp_r;
  assign src.rd0   = rd0_ok_r ? rd0_r : 32'd0;
  assign src.rd1   = rd1_ok_r ? rd1_r : 32'd0;
  assign src.len   = taken_r;

endmodule

>>> rtl/core/xmea_agen.sv
module xmea_agen
  import xmea_pkg::*;
(
  input  ea_src_t src,
  output ea_res_t res
);

  logic [1:0]  md;
  logic [2:0]  rm;
  logic [31:0] d8;
  logic        sib_form;
  logic [2:0]  base;
  logic        no_base;
  logic [31:0] base32, idx32, dterm32, sum32;
  logic        ss32;
  logic [15:0] base16, idx16, dterm16, sum16;
  logic        ss16;

  assign md = src.modrm[7:6];
  assign rm = src.modrm[2:0];
  assign d8 = {{24{src.disp[7]}}, src.disp[7:0]};

  // 32-bit form: base or disp32, scaled index, displacement
  always_comb begin
    sib_form = (rm == 3'd4);
    base     = sib_form ? src.sib[2:0] : rm;
    no_base  = (md == 2'd0) && (base == 3'd5);
    base32   = no_base ? src.disp : src.rd0;
    ss32     = !no_base && (base == 3'd4 || base == 3'd5);
    idx32    = (sib_form && src.sib[5:3] != 3'd4) ? (src.rd1 << src.sib[7:6]) : 32'd0;
    case (md)
      2'd1:    dterm32 = d8;
      2'd2:    dterm32 = src.disp;
      default: dterm32 = 32'd0;
    endcase
    sum32 = base32 + idx32 + dterm32;
  end

  // 16-bit form: bx/bp plus si/di table, wraps at 16 bits
  always_comb begin
    base16 = (rm == 3'd6 && md == 2'd0) ? (src.disp[15:0] & MASK16) : src.rd0[15:0];
    idx16  = (rm[2] == 1'b0) ? src.rd1[15:0] : 16'd0;
    ss16   = (rm == 3'd2) || (rm == 3'd3) || (rm == 3'd6 && md != 2'd0);
    case (md)
      2'd1:    dterm16 = d8[15:0];
      2'd2:    dterm16 = src.disp[15:0];
      default: dterm16 = 16'd0;
    endcase
    sum16 = base16 + idx16 + dterm16;
  end

  assign res.offset        = src.wide ? sum32 : {16'd0, sum16};
  assign res.stack_segment = src.wide ? ss32 : ss16;
  assign res.length        = src.len;

endmodule

>>> rtl/core/xmea_outq.sv
module xmea_outq
  import xmea_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ea_res_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output ea_res_t out_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  ea_res_t main_r, main_nxt;
  ea_res_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_valid_r && out_ready;

  // two-entry queue: output register plus skid entry
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (!main_valid_r) begin
      main_valid_nxt = push;
      main_nxt       = push_data;
    end else if (!skid_valid_r) begin
      skid_valid_nxt = push;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

>>> rtl/core/xmea_checker.sv
`include "x86_modrm_effective_address_assert.svh"

module xmea_checker
  import xmea_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result beat holds
  `XMEA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // byte count stays within modrm plus sib plus disp32
  `XMEA_ASSERT_IMPL(a_len_range, out_tvalid, out_tdata[35:33] != 3'd0 && out_tdata[35:33] != 3'd7 && out_tdata[39:36] == 4'd0, "result length out of range")

  // input stalls only behind a waiting result
  `XMEA_ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid, "input stalled with no result pending")

  // a 16-bit register-form modrm finishes at once
  `XMEA_ASSERT_NEXT(a_reg_form, in_tvalid && in_tready && in_tuser == OP_MODRM && !in_tdata[43] && in_tdata[42:41] == 2'd3, ##1 out_tvalid, "register-form decode gave no result")

endmodule

bind x86_modrm_effective_address xmea_checker u_xmea_checker (.*);

>>> tb/tb_x86_modrm_effective_address.sv
module tb_x86_modrm_effective_address;
  import xmea_pkg::*;

  // beat code that the block must ignore
  localparam logic [1:0] OP_NONE = 2'd3;

  // mod field
  localparam logic [1:0] MOD_MEM = 2'd0;
  localparam logic [1:0] MOD_D8  = 2'd1;
  localparam logic [1:0] MOD_DW  = 2'd2;
  localparam logic [1:0] MOD_REG = 2'd3;

  // register numbers
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_SP = 3'd4;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  // 32-bit rm and sib encodings with a special meaning
  localparam logic [2:0] RM32_SIB    = 3'd4;
  localparam logic [2:0] RM32_DIRECT = 3'd5;
  localparam logic [2:0] BASE_NONE   = 3'd5;
  localparam logic [2:0] INDEX_NONE  = 3'd4;

  // 16-bit rm table
  localparam logic [2:0] RM16_BX_SI  = 3'd0;
  localparam logic [2:0] RM16_BX_DI  = 3'd1;
  localparam logic [2:0] RM16_BP_SI  = 3'd2;
  localparam logic [2:0] RM16_BP_DI  = 3'd3;
  localparam logic [2:0] RM16_SI     = 3'd4;
  localparam logic [2:0] RM16_DI     = 3'd5;
  localparam logic [2:0] RM16_DIRECT = 3'd6;
  localparam logic [2:0] RM16_BX     = 3'd7;

  localparam int unsigned TIMEOUT      = 20_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          ITEM_TARGET  = 1000;

  typedef enum logic [1:0] {DEC_IDLE, DEC_SIB, DEC_DISP} dec_phase_t;

  // tracks the register file and the open decode, queues the addresses it predicts
  class ea_scoreboard;
    logic [31:0] gpr [0:7];
    dec_phase_t  phase;
    logic        wide;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [2:0]  left;
    logic [2:0]  taken;
    ea_res_t     address_q [$];
    int          mismatches;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      phase      = DEC_IDLE;
      wide       = 1'b0;
      modrm      = '0;
      sib        = '0;
      disp       = '0;
      left       = '0;
      taken      = '0;
      mismatches = 0;
    endfunction

    static function logic [2:0] disp_bytes(logic [1:0] md, logic as_base, logic a32);
      case (md)
        MOD_D8:  return 3'd1;
        MOD_DW:  return a32 ? 3'd4 : 3'd2;
        MOD_MEM: return as_base ? (a32 ? 3'd4 : 3'd2) : 3'd0;
        default: return 3'd0;
      endcase
    endfunction

    function logic [31:0] low_half(logic [2:0] r);
      return {16'h0, gpr[r][15:0]};
    endfunction

    // form the address from the held bytes and the registers as they stand now
    function void complete_decode();
      logic [1:0]  md;
      logic [2:0]  rm;
      logic [2:0]  base;
      logic [2:0]  idx;
      logic [31:0] off;
      logic        ss;
      md   = modrm[7:6];
      rm   = modrm[2:0];
      base = sib[2:0];
      idx  = sib[5:3];
      off  = '0;
      ss   = 1'b0;
      if (wide) begin
        if (rm == RM32_SIB) begin
          if (base == BASE_NONE && md == MOD_MEM) begin
            off = disp;
          end else begin
            off = gpr[base];
            ss  = (base == REG_SP || base == REG_BP);
          end
          if (idx != INDEX_NONE) off = off + (gpr[idx] << sib[7:6]);
        end else if (rm == RM32_DIRECT && md == MOD_MEM) begin
          off = disp;
        end else begin
          off = gpr[rm];
          ss  = (rm == REG_BP);
        end
        if (md == MOD_D8) off = off + {{24{disp[7]}}, disp[7:0]};
        else if (md == MOD_DW) off = off + disp;
      end else begin
        case (rm)
          RM16_BX_SI: off = low_half(REG_BX) + low_half(REG_SI);
          RM16_BX_DI: off = low_half(REG_BX) + low_half(REG_DI);
          RM16_BP_SI: begin
            off = low_half(REG_BP) + low_half(REG_SI);
            ss  = 1'b1;
          end
          RM16_BP_DI: begin
            off = low_half(REG_BP) + low_half(REG_DI);
            ss  = 1'b1;
          end
          RM16_SI:    off = low_half(REG_SI);
          RM16_DI:    off = low_half(REG_DI);
          RM16_DIRECT: begin
            if (md == MOD_MEM) begin
              off = {16'h0, disp[15:0]};
            end else begin
              off = low_half(REG_BP);
              ss  = 1'b1;
            end
          end
          default:    off = low_half(REG_BX);
        endcase
        if (md == MOD_D8) off = off + {{24{disp[7]}}, disp[7:0]};
        else if (md == MOD_DW) off = off + {16'h0, disp[15:0]};
        off = off & {16'h0, MASK16};
      end
      address_q.push_back('{length: taken, stack_segment: ss, offset: off});
      phase = DEC_IDLE;
      left  = '0;
    endfunction

    // one accepted input beat
    function void note_beat(logic [1:0] op, logic [2:0] idx, logic [31:0] val,
                            logic [7:0] b, logic a32);
      logic [2:0] header;
      logic [1:0] pos;
      case (op)
        OP_WRITE: gpr[idx] = val;
        OP_MODRM: begin
          wide  = a32;
          modrm = b;
          sib   = '0;
          disp  = '0;
          taken = 3'd1;
          left  = 3'd0;
          if (a32 && b[2:0] == RM32_SIB) begin
            phase = DEC_SIB;
          end else begin
            left = disp_bytes(b[7:6], a32 ? (b[2:0] == RM32_DIRECT) : (b[2:0] == RM16_DIRECT),
                              a32);
            if (left == 3'd0) complete_decode();
            else phase = DEC_DISP;
          end
        end
        OP_BYTE: begin
          if (phase == DEC_SIB) begin
            sib   = b;
            taken = 3'd2;
            left  = disp_bytes(modrm[7:6], b[2:0] == BASE_NONE, 1'b1);
            if (left == 3'd0) complete_decode();
            else phase = DEC_DISP;
          end else if (phase == DEC_DISP) begin
            // little endian: byte position counts from the first displacement byte
            header = (wide && modrm[2:0] == RM32_SIB) ? 3'd2 : 3'd1;
            pos    = 2'(taken - header);
            disp   = disp | ({24'h0, b} << (8 * pos));
            taken  = taken + 3'd1;
            left   = left - 3'd1;
            if (left == 3'd0) complete_decode();
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted output beat against the oldest predicted address
    function void check_result(logic [39:0] beat);
      ea_res_t got;
      ea_res_t want;
      got = beat[35:0];
      if (address_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: offset %h ss %0d length %0d",
                   got.offset, got.stack_segment, got.length);
      end else begin
        want = address_q.pop_front();
        if (got.offset !== want.offset || got.stack_segment !== want.stack_segment ||
            got.length !== want.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: offset exp %h got %h, ss exp %0d got %0d, length exp %0d got %0d",
                     want.offset, got.offset, want.stack_segment, got.stack_segment,
                     want.length, got.length);
        end
      end
    endfunction

    function int pending();
      return address_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  ea_scoreboard sb;
  int           burst_left = 0;
  int           items = 0;

  x86_modrm_effective_address u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sender gap: mostly short, a few long, with the odd stretch of none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // one input beat, held until accepted
  task automatic send_beat(input logic [1:0] op, input logic [2:0] idx, input logic [31:0] val,
                           input logic [7:0] b, input logic a32);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, a32, b, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(op, idx, val, b, a32);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    send_beat(OP_WRITE, idx, val, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [1:0] op, input logic [7:0] b, input logic a32);
    send_beat(op, 3'($urandom), $urandom, b, a32);
  endtask

  // modrm, optional sib and displacement; a broken one stops short
  task automatic send_decode(input bit whole);
    logic       a32;
    logic [7:0] modrm;
    logic [7:0] b;
    logic       as_base;
    int         need;
    a32   = 1'($urandom);
    modrm = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      a32        = 1'b1;
      modrm[2:0] = RM32_SIB;
    end
    send_byte(OP_MODRM, modrm, a32);
    items++;
    as_base = a32 ? (modrm[2:0] == RM32_DIRECT) : (modrm[2:0] == RM16_DIRECT);
    if (a32 && modrm[2:0] == RM32_SIB) begin
      if (!whole && $urandom_range(0, 2) == 0) return;
      b = 8'($urandom);
      send_byte(OP_BYTE, b, 1'($urandom));
      items++;
      as_base = (b[2:0] == BASE_NONE);
    end
    need = int'(ea_scoreboard::disp_bytes(modrm[7:6], as_base, a32));
    if (!whole) need = (need > 0) ? $urandom_range(0, need - 1) : 0;
    for (int i = 0; i < need; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(3'($urandom), $urandom);
        items++;
      end
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'h80;
        3:       b = 8'h7F;
        default: b = 8'($urandom);
      endcase
      send_byte(OP_BYTE, b, 1'($urandom));
      items++;
    end
  endtask

  // hold the sender until every predicted address has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int          sel;
    int          next_drain;
    logic [31:0] val;
    sb         = new();
    next_drain = 250;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_WRITE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register extremes
    write_reg(REG_BX, 32'hFFFF_FFFF);
    write_reg(REG_BP, 32'h8000_0000);
    write_reg(REG_SI, 32'h0000_FFFF);
    write_reg(REG_SP, 32'h7FFF_FFFF);
    // unused code, then a byte with no decode open
    send_byte(OP_NONE, 8'hFF, 1'b1);
    send_byte(OP_BYTE, 8'h00, 1'b0);
    // register form with rm 4 still takes a sib: no index, esp base, scale 8
    send_byte(OP_MODRM, {MOD_REG, 3'd0, RM32_SIB}, 1'b1);
    send_byte(OP_BYTE, {2'd3, INDEX_NONE, REG_SP}, 1'b0);
    // disp32 in place of the base
    send_byte(OP_MODRM, {MOD_MEM, 3'd7, RM32_DIRECT}, 1'b1);
    repeat (4) send_byte(OP_BYTE, 8'hFF, 1'b0);
    // ebp base, esi scaled by 8, negative disp8
    send_byte(OP_MODRM, {MOD_D8, 3'd2, RM32_SIB}, 1'b1);
    send_byte(OP_BYTE, {2'd3, REG_SI, REG_BP}, 1'b1);
    send_byte(OP_BYTE, 8'h80, 1'b0);
    // bp+si with disp16 dropped by a fresh modrm in register form
    send_byte(OP_MODRM, {MOD_DW, 3'd0, RM16_BP_SI}, 1'b0);
    send_byte(OP_BYTE, 8'hFF, 1'b0);
    send_byte(OP_MODRM, {MOD_REG, 3'd5, RM16_BX}, 1'b0);
    // register write lands between modrm and its displacement
    send_byte(OP_MODRM, {MOD_D8, 3'd1, RM16_BP_DI}, 1'b0);
    write_reg(REG_DI, 32'hFFFF_FFFF);
    send_byte(OP_BYTE, 8'h7F, 1'b1);
    // 16-bit direct disp16
    send_byte(OP_MODRM, {MOD_MEM, 3'd0, RM16_DIRECT}, 1'b0);
    send_byte(OP_BYTE, 8'h00, 1'b0);
    send_byte(OP_BYTE, 8'h80, 1'b0);

    // random mix, mostly whole decodes
    while (items < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        case ($urandom_range(0, 5))
          0:       val = 32'h0000_0000;
          1:       val = 32'hFFFF_FFFF;
          2:       val = 32'h8000_0000;
          3:       val = 32'h0000_FFFF;
          default: val = $urandom;
        endcase
        write_reg(3'($urandom), val);
        items++;
      end else if (sel < 22) begin
        if ($urandom_range(0, 1) == 0) send_byte(OP_NONE, 8'($urandom), 1'($urandom));
        else send_byte(OP_BYTE, 8'($urandom), 1'($urandom));
      end else if (sel < 28) begin
        send_decode(1'b0);
      end else begin
        send_decode(1'b1);
      end
      if (items >= next_drain) begin
        drain_results();
        next_drain += 250;
      end
    end

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int hi;
    int lo;
    int r;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r  = $urandom_range(0, 99);
      hi = (r < 5) ? $urandom_range(40, 100) : $urandom_range(1, 8);
      r  = $urandom_range(0, 99);
      if (r < 30) lo = 0;
      else if (r < 80) lo = $urandom_range(1, 3);
      else if (r < 95) lo = $urandom_range(4, 10);
      else lo = $urandom_range(20, 40);
      out_tready <= 1'b1;
      repeat (hi) @(posedge clk);
      if (lo > 0) begin
        out_tready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // run limit
  initial begin
    #(TIMEOUT);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/xmea_pkg.sv
rtl/core/xmea_seq.sv
rtl/core/xmea_agen.sv
rtl/core/xmea_outq.sv
rtl/core/x86_modrm_effective_address.sv
rtl/core/xmea_checker.sv
tb/tb_x86_modrm_effective_address.sv
